/* sv/bbc_pkg.sv */
package bbc_pkg;

  // Status codes carried on the result channel
  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_SUCCESS  = 3'd1,
    ST_NO_OPEN  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_UNCLOSED = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  // Class of a character after decode
  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_OTHER = 2'd2
  } op_e;

  // Bracket kinds as stored on the stack
  localparam logic [1:0] KIND_PAREN = 2'd0;
  localparam logic [1:0] KIND_BRACE = 2'd1;
  localparam logic [1:0] KIND_SQUARE = 2'd2;

  // Character codes
  localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
  localparam logic [7:0] CH_OPEN_BRACE   = 8'h7B;
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
  localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
  localparam logic [7:0] CH_CLOSE_BRACE  = 8'h7D;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

  // Decoded command passed from front to back
  typedef struct packed {
    op_e        op;
    logic [1:0] kind;
    logic       last;
  } cmd_t;

endpackage

/* sv/bbc_if.sv */
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface bbc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       done_res;

  modport source (output valid, output status, output done_res, input ready);
  modport sink (input valid, input status, input done_res, output ready);
endinterface

/* sv/bbc_front.sv */
module bbc_front (
  bbc_in_if.sink         in_i,
  output logic           cmd_valid_o,
  output bbc_pkg::cmd_t  cmd_o,
  input  logic           cmd_ready_i
);
  import bbc_pkg::*;

  // Decode the character into an opening, closing or other command
  always_comb begin
    cmd_o.last = in_i.last;
    cmd_o.op   = OP_OTHER;
    cmd_o.kind = KIND_PAREN;
    case (in_i.symbol)
      CH_OPEN_PAREN: begin
        cmd_o.op   = OP_OPEN;
        cmd_o.kind = KIND_PAREN;
      end
      CH_OPEN_BRACE: begin
        cmd_o.op   = OP_OPEN;
        cmd_o.kind = KIND_BRACE;
      end
      CH_OPEN_SQUARE: begin
        cmd_o.op   = OP_OPEN;
        cmd_o.kind = KIND_SQUARE;
      end
      CH_CLOSE_PAREN: begin
        cmd_o.op   = OP_CLOSE;
        cmd_o.kind = KIND_PAREN;
      end
      CH_CLOSE_BRACE: begin
        cmd_o.op   = OP_CLOSE;
        cmd_o.kind = KIND_BRACE;
      end
      CH_CLOSE_SQUARE: begin
        cmd_o.op   = OP_CLOSE;
        cmd_o.kind = KIND_SQUARE;
      end
      default: begin
        cmd_o.op   = OP_OTHER;
        cmd_o.kind = KIND_PAREN;
      end
    endcase
  end

  // Pass the handshake straight to the queue
  assign cmd_valid_o = in_i.valid;
  assign in_i.ready  = cmd_ready_i;

endmodule

/* sv/bbc_queue.sv */
module bbc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  bbc_pkg::cmd_t  wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output bbc_pkg::cmd_t  rd_cmd_o
);
  import bbc_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       wr_en, rd_en;

  assign wr_ready_o = (fill_q != 2'd2);
  assign rd_valid_o = (fill_q != 2'd0);
  assign rd_cmd_o   = slot_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // Store incoming commands
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_q <= ~wr_ptr_q;
      if (rd_en) rd_ptr_q <= ~rd_ptr_q;
      if (wr_en && !rd_en) begin
        fill_q <= fill_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

/* sv/bbc_back.sv */
module bbc_back #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  bbc_pkg::cmd_t  cmd_i,
  bbc_out_if.source      out_o
);
  import bbc_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [1:0]    mem [STACK_DEPTH];
  logic [CW-1:0] count_q, count_nx;
  logic [1:0]    top_q, sec_q;
  status_e       err_q, err_d, status_d;
  logic          out_valid_q, out_done_q;
  status_e       out_status_q;
  logic          fire, push, pop, full, empty;
  logic [IW-1:0] wr_idx, rd_idx;

  // Take a command whenever the output register is free or drains
  assign fire        = cmd_valid_i && (!out_valid_q || out_o.ready);
  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign full        = (count_q == CW'(STACK_DEPTH));
  assign empty       = (count_q == '0);
  assign wr_idx      = count_q[IW-1:0];
  assign rd_idx      = IW'(count_q - CW'(3));

  // Execute the command against the stack top
  always_comb begin
    push  = 1'b0;
    pop   = 1'b0;
    err_d = err_q;
    if (err_q == ST_RUNNING) begin
      case (cmd_i.op)
        OP_OPEN: begin
          if (full) err_d = ST_OVERFLOW;
          else push = 1'b1;
        end
        OP_CLOSE: begin
          if (!empty && top_q == cmd_i.kind) pop = 1'b1;
          else err_d = empty ? ST_NO_OPEN : ST_MISMATCH;
        end
        default: begin
          err_d = empty ? ST_NO_OPEN : ST_MISMATCH;
        end
      endcase
    end
    if (push) begin
      count_nx = count_q + CW'(1);
    end else if (pop) begin
      count_nx = count_q - CW'(1);
    end else begin
      count_nx = count_q;
    end
    if (!cmd_i.last) begin
      status_d = err_d;
    end else if (err_d != ST_RUNNING) begin
      status_d = err_d;
    end else if (count_nx == '0) begin
      status_d = ST_SUCCESS;
    end else begin
      status_d = ST_UNCLOSED;
    end
  end

  // Write pushed entries and prefetch the entry below the top
  always_ff @(posedge clk_i) begin
    if (fire && push) begin
      mem[wr_idx] <= cmd_i.kind;
      sec_q       <= top_q;
    end else if (fire && pop) begin
      sec_q <= mem[rd_idx];
    end
    if (fire && push) begin
      top_q <= cmd_i.kind;
    end else if (fire && pop) begin
      top_q <= sec_q;
    end
  end

  // Update count, latched error and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      err_q        <= ST_RUNNING;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_RUNNING;
      out_done_q   <= 1'b0;
    end else begin
      if (fire) begin
        count_q      <= cmd_i.last ? '0 : count_nx;
        err_q        <= cmd_i.last ? ST_RUNNING : err_d;
        out_valid_q  <= 1'b1;
        out_status_q <= status_d;
        out_done_q   <= cmd_i.last;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.done_res = out_done_q;

endmodule

/* sv/bracket_balance_checker.sv */
// Channel  Dir  Payload                     Handshake
// in_i     in   symbol[7:0], last           valid/ready
// out_o    out  status[2:0], done_res       valid/ready
//
// One character per cycle sustained while the result channel is not stalled; each accepted
// character is held in the queue, then its result in the output register.
// The stack top and the entry below it sit in registers, so a push or pop every cycle a
// command fires is served by one memory write port and one registered read port.
// Reset clears the stack count, the latched error and all handshake state.
// A two-entry queue between decode and stack logic absorbs a stalled result;
// input ready drops only when the queue is full.
module bracket_balance_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bbc_in_if.sink    in_i,
  bbc_out_if.source out_o
);
  import bbc_pkg::*;

  logic front_valid, front_ready, back_valid, back_ready;
  cmd_t front_cmd, back_cmd;

  // Decode characters
  bbc_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  // Buffer decoded commands
  bbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_cmd_i   (front_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready),
    .rd_cmd_o   (back_cmd)
  );

  // Run the stack and give results
  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_o       (out_o)
  );

endmodule

/* sv/bbc_checker.sv */
module bbc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] out_status_i,
  input logic       out_done_i
);
  import bbc_pkg::*;

  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track items accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_done_i))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 3'd0)
    else $error("result without an accepted item");

  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_done_i |-> out_status_i != ST_RUNNING)
    else $error("final verdict reports running");

  a_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_done_i |->
      out_status_i != ST_SUCCESS && out_status_i != ST_UNCLOSED)
    else $error("final-only status on a running result");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more items in flight than buffering allows");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_done_i   (out_o.done_res)
);
